### sv/motor_speed_ramp_commander_top_defines.svh
// Assertion macros shared by the speed ramp commander checker.
`ifndef MOTOR_SPEED_RAMP_COMMANDER_TOP_DEFINES_SVH
`define MOTOR_SPEED_RAMP_COMMANDER_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MSRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define MSRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/msrc_pkg.sv
// Package: types, codes and duty table of the speed ramp commander.
package msrc_pkg;

    localparam int SPD_W  = 4;
    localparam int DUTY_W = 7;
    localparam int DIST_W = 10;
    localparam int BYTE_W = 8;

    localparam int SPEED_LEVELS_DEF = 10;
    localparam logic [DIST_W-1:0] THR_RESET = 10'd40;

    localparam logic [BYTE_W-1:0] CHR_W  = 8'h57;
    localparam logic [BYTE_W-1:0] CHR_S  = 8'h53;
    localparam logic [BYTE_W-1:0] CHR_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHR_D  = 8'h44;
    localparam logic [BYTE_W-1:0] CHR_O  = 8'h4F;
    localparam logic [BYTE_W-1:0] CHR_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_9  = 8'h39;

    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_DIST = 1'b1;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_W    = 3'd1,
        PEND_S    = 3'd2,
        PEND_A    = 3'd3,
        PEND_D    = 3'd4,
        PEND_O    = 3'd5
    } t_pend;

    typedef struct packed {
        logic load;
        logic plan;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic has_run;
        logic out_free;
        logic ramp_end;
    } t_dp_sts;

    function automatic logic [DUTY_W-1:0] duty_of(input logic [SPD_W-1:0] spd);
        logic [DUTY_W-1:0] d;
        case (spd)
            4'd0:    d = 7'd0;
            4'd1:    d = 7'd10;
            4'd2:    d = 7'd20;
            4'd3:    d = 7'd30;
            4'd4:    d = 7'd40;
            4'd5:    d = 7'd50;
            4'd6:    d = 7'd60;
            4'd7:    d = 7'd75;
            4'd8:    d = 7'd80;
            default: d = 7'd90;
        endcase
        return d;
    endfunction

endpackage

### sv/msrc_intf.sv
// Handshake interfaces: input items, result items and the threshold write channel.
interface msrc_in_if
    import msrc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [BYTE_W-1:0] cmd_byte;
    logic [DIST_W-1:0] distance_cm;

    modport source (output valid, func, cmd_byte, distance_cm, input ready);
    modport sink   (input valid, func, cmd_byte, distance_cm, output ready);
endinterface

interface msrc_out_if
    import msrc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        drive_direction;
    logic [SPD_W-1:0]  speed_step;
    logic [DUTY_W-1:0] duty_percent;
    logic              alarm;
    logic              last;

    modport source (output valid, drive_direction, speed_step, duty_percent, alarm, last,
                    input ready);
    modport sink   (input valid, drive_direction, speed_step, duty_percent, alarm, last,
                    output ready);
endinterface

interface msrc_cfg_if
    import msrc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### sv/msrc_ctrl.sv
// Controller: sequences load, plan and ramp emission of one item.
module msrc_ctrl
    import msrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLAN,
        S_RAMP
    } t_state;

    t_state r_state;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.plan = (r_state == S_PLAN);
        o_cmd.emit = (r_state == S_RAMP) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_state <= i_sts.has_run ? S_RAMP : S_IDLE;
                end
                S_RAMP: begin
                    if (i_sts.out_free && i_sts.ramp_end) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### sv/msrc_dp.sv
// Datapath: command latches, motor state, ramp stepper and result register.
module msrc_dp
    import msrc_pkg::*;
#(
    parameter int SPEED_LEVELS = SPEED_LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_func,
    input  logic [BYTE_W-1:0] i_cmd_byte,
    input  logic [DIST_W-1:0] i_distance_cm,
    input  logic              i_cfg_valid,
    input  logic [DIST_W-1:0] i_cfg_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_drive_direction,
    output logic [SPD_W-1:0]  o_speed_step,
    output logic [DUTY_W-1:0] o_duty_percent,
    output logic              o_alarm,
    output logic              o_last
);

    localparam logic [SPD_W:0] LEVELS = (SPD_W+1)'(SPEED_LEVELS);

    logic [DIST_W-1:0] r_thr;
    logic              r_func;
    logic [DIST_W-1:0] r_dist;
    t_pend             r_pend_dir;
    logic              r_pend_vld;
    logic [SPD_W-1:0]  r_pend_spd;
    logic [SPD_W-1:0]  r_cur_spd;
    t_dir              r_cur_dir;
    t_dir              r_run_dir;
    logic [SPD_W-1:0]  r_step;
    logic [SPD_W-1:0]  r_tgt;
    logic              r_alarm;
    logic              r_second;
    t_dir              r_sec_dir;
    logic [SPD_W-1:0]  r_sec_tgt;
    logic              r_out_valid;
    t_dir              r_out_dir;
    logic [SPD_W-1:0]  r_out_spd;
    logic              r_out_alarm;
    logic              r_out_last;

    logic              is_digit;
    logic              move_run;
    logic              at_tgt;
    t_dir              move_dir;
    logic [SPD_W-1:0]  n_step;

    assign is_digit = (i_cmd_byte >= CHR_0) && (i_cmd_byte <= CHR_9)
                      && ({1'b0, i_cmd_byte[SPD_W-1:0]} < LEVELS);
    assign move_run = r_pend_vld && (r_pend_dir == PEND_W || r_pend_dir == PEND_S);
    assign move_dir = (r_pend_dir == PEND_W) ? DIR_FWD : DIR_BWD;
    assign at_tgt   = (r_step == r_tgt);
    assign n_step   = (r_step < r_tgt) ? r_step + 1'b1 : r_step - 1'b1;

    assign o_sts.has_run  = (r_func == FUNC_DIST) || move_run || (r_pend_dir == PEND_O);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.ramp_end = at_tgt && !r_second;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // item capture and command latches
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_dist <= i_distance_cm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_dir <= PEND_NONE;
            r_pend_vld <= 1'b0;
            r_pend_spd <= '0;
            r_cur_spd  <= '0;
            r_cur_dir  <= DIR_STOP;
            r_second   <= 1'b0;
        end else if (i_cmd.load && i_func == FUNC_CMD) begin
            unique case (i_cmd_byte)
                CHR_W:   r_pend_dir <= PEND_W;
                CHR_S:   r_pend_dir <= PEND_S;
                CHR_A:   r_pend_dir <= PEND_A;
                CHR_D:   r_pend_dir <= PEND_D;
                CHR_O:   r_pend_dir <= PEND_O;
                default: begin
                    if (is_digit) begin
                        r_pend_spd <= i_cmd_byte[SPD_W-1:0];
                        r_pend_vld <= 1'b1;
                    end
                end
            endcase
        end else if (i_cmd.plan) begin
            r_second <= 1'b0;
            if (r_func == FUNC_DIST) begin
                r_step <= r_cur_spd;
                if (r_dist < r_thr && r_cur_dir == DIR_FWD) begin
                    r_run_dir <= DIR_FWD;
                    r_tgt     <= '0;
                    r_alarm   <= 1'b1;
                    r_cur_spd <= '0;
                end else begin
                    r_run_dir <= r_cur_dir;
                    r_tgt     <= r_cur_spd;
                    r_alarm   <= 1'b0;
                end
            end else if (move_run) begin
                r_alarm    <= 1'b0;
                r_step     <= r_cur_spd;
                r_cur_spd  <= r_pend_spd;
                r_cur_dir  <= move_dir;
                r_pend_dir <= PEND_NONE;
                r_pend_vld <= 1'b0;
                r_pend_spd <= '0;
                if (r_cur_dir != DIR_STOP && r_cur_dir != move_dir) begin
                    r_run_dir <= r_cur_dir;
                    r_tgt     <= '0;
                    r_second  <= 1'b1;
                    r_sec_dir <= move_dir;
                    r_sec_tgt <= r_pend_spd;
                end else begin
                    r_run_dir <= move_dir;
                    r_tgt     <= r_pend_spd;
                end
            end else if (r_pend_dir == PEND_O) begin
                r_alarm    <= 1'b0;
                r_run_dir  <= r_cur_dir;
                r_step     <= (r_cur_dir == DIR_STOP) ? '0 : r_cur_spd;
                r_tgt      <= '0;
                r_cur_spd  <= '0;
                r_cur_dir  <= DIR_STOP;
                r_pend_dir <= PEND_NONE;
                r_pend_vld <= 1'b0;
                r_pend_spd <= '0;
            end
        end else if (i_cmd.emit) begin
            if (at_tgt) begin
                if (r_second) begin
                    // reversal: down phase done, climb from zero
                    r_second  <= 1'b0;
                    r_step    <= '0;
                    r_run_dir <= r_sec_dir;
                    r_tgt     <= r_sec_tgt;
                end
            end else begin
                r_step <= n_step;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_dir   <= r_run_dir;
            r_out_spd   <= r_step;
            r_out_alarm <= r_alarm;
            r_out_last  <= at_tgt && !r_second;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive_direction = r_out_dir;
    assign o_speed_step      = r_out_spd;
    assign o_duty_percent    = duty_of(r_out_spd);
    assign o_alarm           = r_out_alarm;
    assign o_last            = r_out_last;

endmodule

### sv/motor_speed_ramp_commander_top.sv
// Top level of the motor speed ramp commander.
// Takes command bytes (W/S/A/D/O, digits) and distance samples one item at a time and
// emits one result per speed step of the resulting ramp, with last set on the final one.
// An item yields 0 to 20 results and holds the block until the last one is out. It is
// latched in idle and planned in the plan state; then one result per cycle comes from
// the stepper while the output register drains; a stalled output holds the stepper.
// The threshold write channel is always ready and should be written only while idle.
module motor_speed_ramp_commander_top
    import msrc_pkg::*;
#(
    parameter int SPEED_LEVELS = SPEED_LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    msrc_in_if.sink           i_cmd,
    msrc_out_if.source        o_res,
    msrc_cfg_if.sink          i_cfg
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign i_cfg.ready = 1'b1;

    msrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    msrc_dp #(
        .SPEED_LEVELS (SPEED_LEVELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts),
        .i_func            (i_cmd.func),
        .i_cmd_byte        (i_cmd.cmd_byte),
        .i_distance_cm     (i_cmd.distance_cm),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_data        (i_cfg.data),
        .i_out_ready       (o_res.ready),
        .o_out_valid       (o_res.valid),
        .o_drive_direction (o_res.drive_direction),
        .o_speed_step      (o_res.speed_step),
        .o_duty_percent    (o_res.duty_percent),
        .o_alarm           (o_res.alarm),
        .o_last            (o_res.last)
    );

endmodule

### sv/msrc_checker.sv
// Port-level checker for the speed ramp commander, bound to the top level.
`include "motor_speed_ramp_commander_top_defines.svh"

module msrc_checker
    import msrc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       i_out_dir,
    input logic [SPD_W-1:0] i_out_spd,
    input logic             i_out_last
);

    `MSRC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_spd) && $stable(i_out_dir) && $stable(i_out_last),
        "result item changed while stalled")

    `MSRC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready,
        "input taken again right after an item")

    `MSRC_ASSERT_NOW(a_no_input_mid_run, i_out_valid && !i_out_last, !i_in_ready,
        "input ready while a run is still emitting")

    `MSRC_ASSERT_NEXT(a_run_continues, i_out_valid && i_out_ready && !i_out_last,
        i_out_valid, "run stalled after a non-final result item")

endmodule

bind motor_speed_ramp_commander_top msrc_checker u_msrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_dir   (o_res.drive_direction),
    .i_out_spd   (o_res.speed_step),
    .i_out_last  (o_res.last)
);

### sim/motor_speed_ramp_commander_top_tb.sv
// Testbench for the motor speed ramp commander: random and directed items, scoreboard check.
`timescale 1ns / 1ps

module motor_speed_ramp_commander_top_tb
    import msrc_pkg::*;
;

    typedef struct packed {
        t_dir              dir;
        logic [SPD_W-1:0]  spd;
        logic [DUTY_W-1:0] duty;
        logic              alarm;
        logic              last;
    } t_ramp_step;

    class t_ramp_scoreboard;
        t_ramp_step        expected_steps[$];
        int                errors;
        int                speed_levels;
        logic [DIST_W-1:0] threshold;
        t_pend             pend_dir;
        bit                pend_spd_ok;
        logic [SPD_W-1:0]  pend_spd;
        logic [SPD_W-1:0]  cur_spd;
        t_dir              cur_dir;
        logic [DUTY_W-1:0] duty_lut [16] = '{7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60,
                                             7'd75, 7'd80, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90,
                                             7'd90, 7'd90};

        function new(int levels);
            speed_levels = levels;
            errors       = 0;
            threshold    = THR_RESET;
            cur_spd      = '0;
            cur_dir      = DIR_STOP;
            clear_pending();
        endfunction

        function void clear_pending();
            pend_dir    = PEND_NONE;
            pend_spd_ok = 1'b0;
            pend_spd    = '0;
        endfunction

        function void push_step(t_dir d, logic [SPD_W-1:0] s, logic alarm);
            t_ramp_step st;
            st.dir   = d;
            st.spd   = s;
            st.duty  = duty_lut[s];
            st.alarm = alarm;
            st.last  = 1'b0;
            expected_steps.push_back(st);
        endfunction

        function void ramp_to(t_dir d, logic [SPD_W-1:0] from_spd, logic [SPD_W-1:0] to_spd,
                              logic alarm);
            logic [SPD_W-1:0] s;
            s = from_spd;
            while (1) begin
                push_step(d, s, alarm);
                if (s == to_spd)
                    break;
                s = (s < to_spd) ? s + 1'b1 : s - 1'b1;
            end
        endfunction

        function void run_move(t_dir d);
            if (cur_dir != DIR_STOP && cur_dir != d) begin
                ramp_to(cur_dir, cur_spd, '0, 1'b0);
                cur_spd = '0;
            end
            ramp_to(d, cur_spd, pend_spd, 1'b0);
            cur_spd = pend_spd;
            cur_dir = d;
            clear_pending();
        endfunction

        function void run_stop();
            if (cur_dir != DIR_STOP)
                ramp_to(cur_dir, cur_spd, '0, 1'b0);
            else
                push_step(DIR_STOP, '0, 1'b0);
            cur_spd = '0;
            cur_dir = DIR_STOP;
            clear_pending();
        endfunction

        function void note_item(logic f, logic [BYTE_W-1:0] b, logic [DIST_W-1:0] dist_cm);
            int first;
            first = expected_steps.size();
            if (f == FUNC_DIST) begin
                if (dist_cm < threshold && cur_dir == DIR_FWD) begin
                    ramp_to(DIR_FWD, cur_spd, '0, 1'b1);
                    cur_spd = '0;
                end else begin
                    push_step(cur_dir, cur_spd, 1'b0);
                end
            end else begin
                case (b)
                    CHR_W: pend_dir = PEND_W;
                    CHR_S: pend_dir = PEND_S;
                    CHR_A: pend_dir = PEND_A;
                    CHR_D: pend_dir = PEND_D;
                    CHR_O: pend_dir = PEND_O;
                    default: begin
                        if (b >= CHR_0 && b <= CHR_9 && int'(b - CHR_0) < speed_levels) begin
                            pend_spd    = SPD_W'(b - CHR_0);
                            pend_spd_ok = 1'b1;
                        end
                    end
                endcase
                if (pend_dir == PEND_W && pend_spd_ok)
                    run_move(DIR_FWD);
                else if (pend_dir == PEND_S && pend_spd_ok)
                    run_move(DIR_BWD);
                else if (pend_dir == PEND_O)
                    run_stop();
            end
            if (expected_steps.size() > first)
                expected_steps[expected_steps.size()-1].last = 1'b1;
        endfunction

        function void cmp_field(string what, logic [7:0] want, logic [7:0] seen);
            if (seen !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, what, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_ramp_step got);
            t_ramp_step want;
            if (expected_steps.size() == 0) begin
                $display("%0t: unexpected result expected none, got dir %0d spd %0d duty %0d",
                         $time, got.dir, got.spd, got.duty);
                errors++;
                return;
            end
            want = expected_steps.pop_front();
            cmp_field("drive_direction", 8'(want.dir), 8'(got.dir));
            cmp_field("speed_step", 8'(want.spd), 8'(got.spd));
            cmp_field("duty_percent", 8'(want.duty), 8'(got.duty));
            cmp_field("alarm", 8'(want.alarm), 8'(got.alarm));
            cmp_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    localparam longint CYCLE_LIMIT = 300000;

    logic   i_clk;
    logic   i_rst_n;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_left;
    longint cycles;

    t_ramp_scoreboard sb;

    msrc_in_if  cmd_if ();
    msrc_out_if res_if ();
    msrc_cfg_if cfg_if ();

    motor_speed_ramp_commander_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("motor_speed_ramp_commander_top_tb: errors");
            $finish;
        end
    end

    // result side: ready changes on the falling edge, long hold when asked
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_ramp_step got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.dir   = t_dir'(res_if.drive_direction);
            got.spd   = res_if.speed_step;
            got.duty  = res_if.duty_percent;
            got.alarm = res_if.alarm;
            got.last  = res_if.last;
            sb.check_result(got);
        end
    end

    // entered and left on a falling edge
    task automatic send_item(input logic f, input logic [BYTE_W-1:0] b,
                             input logic [DIST_W-1:0] dist_cm);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid       = 1'b1;
        cmd_if.func        = f;
        cmd_if.cmd_byte    = b;
        cmd_if.distance_cm = dist_cm;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        sb.note_item(f, b, dist_cm);
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [BYTE_W-1:0] b);
        send_item(FUNC_CMD, b, DIST_W'($urandom_range(1023)));
    endtask

    task automatic send_range(input logic [DIST_W-1:0] dist_cm);
        send_item(FUNC_DIST, BYTE_W'($urandom_range(255)), dist_cm);
    endtask

    task automatic settle();
        cmd_if.valid = 1'b0;
        while (sb.expected_steps.size() != 0)
            @(negedge i_clk);
        // items without results may still be in flight
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [DIST_W-1:0] v);
        cfg_if.valid = 1'b1;
        cfg_if.data  = v;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        sb.threshold = v;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_random();
        int               r;
        int               k;
        logic [DIST_W-1:0] d;
        r = $urandom_range(99);
        if (r < 30) begin
            k = $urandom_range(9);
            if (k < 4)
                d = DIST_W'($urandom_range(1023));
            else if (k < 7)
                d = DIST_W'($urandom_range(int'(sb.threshold)));
            else
                d = DIST_W'($urandom_range(63));
            send_range(d);
        end else if (r < 60) begin
            k = $urandom_range(9);
            if (k < 4)
                send_cmd(CHR_W);
            else if (k < 7)
                send_cmd(CHR_S);
            else if (k == 7)
                send_cmd(CHR_O);
            else if (k == 8)
                send_cmd(CHR_A);
            else
                send_cmd(CHR_D);
        end else if (r < 92) begin
            send_cmd(CHR_0 + BYTE_W'($urandom_range(9)));
        end else begin
            send_cmd(BYTE_W'($urandom_range(255)));
        end
    endtask

    task automatic run_directed();
        send_range(10'd1023);
        send_cmd(CHR_O);
        send_cmd(8'h00);
        send_cmd(8'hFF);
        send_cmd(CHR_9);
        send_cmd(CHR_W);
        send_range(10'd40);
        send_range(10'd39);
        send_range(10'd0);
        send_cmd(CHR_W);
        send_cmd(CHR_0 + 8'd3);
        send_cmd(CHR_S);
        send_cmd(CHR_9);
        send_range(10'd0);
        send_cmd(CHR_W);
        send_cmd(CHR_9);
        send_cmd(CHR_A);
        send_cmd(CHR_0 + 8'd5);
        send_cmd(CHR_D);
        send_cmd(CHR_W);
        send_cmd(CHR_O);
        send_cmd(CHR_S);
        send_cmd(CHR_0);
        send_cmd(CHR_0 - 8'd1);
        send_cmd(CHR_9 + 8'd1);
        send_cmd(CHR_O);
    endtask

    initial begin
        logic [DIST_W-1:0] thr_by_phase [4];
        int                idle_by_phase [4];
        int                stall_by_phase [4];

        sb                 = new(SPEED_LEVELS_DEF);
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.func        = FUNC_CMD;
        cmd_if.cmd_byte    = '0;
        cmd_if.distance_cm = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_left          = 0;

        thr_by_phase   = '{10'd1023, 10'd0, DIST_W'($urandom_range(1022, 1)), 10'd1};
        idle_by_phase  = '{0, 61, 0, 27};
        stall_by_phase = '{0, 0, 61, 27};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_threshold(THR_RESET);
        run_directed();

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            write_threshold(thr_by_phase[ph]);
            send_idle_pct  = idle_by_phase[ph];
            recv_stall_pct = stall_by_phase[ph];
            if (ph == 0) begin
                // results held back while items keep coming, so the input backs up
                @(posedge i_clk);
                hold_left = 300;
                @(negedge i_clk);
            end
            repeat (64) send_random();
        end

        cmd_if.valid = 1'b0;
        while (sb.expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0)
            $display("motor_speed_ramp_commander_top_tb: clean");
        else
            $display("motor_speed_ramp_commander_top_tb: errors");
        $finish;
    end

endmodule
